// File: design/uf2c_pkg.sv
// Shared types and constants for the UF2 block checker.
// No dependencies; every other design file uses this package by scoped name.
package uf2c_pkg;

	localparam int INDEX_WIDTH = 16;

	localparam int ADDR_W = 5;

	typedef logic [INDEX_WIDTH-1:0] index_t;

	typedef enum logic [3:0] {
		ST_OK             = 4'd0,
		ST_VALID          = 4'd1,
		ST_EMPTY          = 4'd2,
		ST_BAD_MAGIC      = 4'd3,
		ST_PAYLOAD_BIG    = 4'd4,
		ST_COUNT_MISMATCH = 4'd5,
		ST_CHAIN_BROKEN   = 4'd6,
		ST_FAMILY_CHANGED = 4'd7,
		ST_WRONG_FAMILY   = 4'd8
	} status_t;

	typedef enum logic [2:0] {
		REG_TOTAL_BLOCKS  = 3'd0,
		REG_MAX_PAYLOAD   = 3'd1,
		REG_MAGIC_FIRST   = 3'd2,
		REG_MAGIC_SECOND  = 3'd3,
		REG_MAGIC_FINAL   = 3'd4,
		REG_FAMILY_MASK   = 3'd5,
		REG_REQ_FAMILY    = 3'd6,
		REG_NONE          = 3'd7
	} reg_idx_t;

	localparam logic [15:0] RST_TOTAL_BLOCKS = 16'd0;
	localparam logic [8:0]  RST_MAX_PAYLOAD  = 9'd476;
	localparam logic [31:0] RST_MAGIC_FIRST  = 32'h0A32_4655;
	localparam logic [31:0] RST_MAGIC_SECOND = 32'h9E5D_5157;
	localparam logic [31:0] RST_MAGIC_FINAL  = 32'h0AB1_6F30;
	localparam logic [31:0] RST_FAMILY_MASK  = 32'h0000_2000;
	localparam logic [31:0] RST_REQ_FAMILY   = 32'hE48B_FF56;

	// classified block header, front to back
	typedef struct packed {
		logic        magic_ok;
		logic        size_ok;
		logic        count_ok;
		logic [31:0] family;
		logic [31:0] block_number;
		logic [31:0] target_address;
		logic [31:0] payload_size;
	} cls_t;

	// configuration the back end needs
	typedef struct packed {
		logic [15:0] total_blocks;
		logic [31:0] required_family;
	} back_cfg_t;

	typedef struct packed {
		status_t     status;
		logic [15:0] block_index;
		logic [31:0] image_family;
		logic [31:0] first_address;
		logic [31:0] end_address;
		logic [31:0] payload_total;
	} result_t;

endpackage

// File: design/uf2c_front.sv
// Front end: configuration registers on the APB-style port and the
// stateless checks of each header. Depends on uf2c_pkg.
module uf2c_front (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [uf2c_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	input  logic [31:0]                start_word_a,
	input  logic [31:0]                start_word_b,
	input  logic [31:0]                block_flags,
	input  logic [31:0]                target_address,
	input  logic [31:0]                payload_size,
	input  logic [31:0]                block_number,
	input  logic [31:0]                block_total,
	input  logic [31:0]                family_or_size,
	input  logic [31:0]                end_word,
	output uf2c_pkg::cls_t             cls,
	output uf2c_pkg::back_cfg_t        back_cfg
);

	logic [15:0] total_blocks_q;
	logic [8:0]  max_payload_q;
	logic [31:0] magic_first_q;
	logic [31:0] magic_second_q;
	logic [31:0] magic_final_q;
	logic [31:0] family_mask_q;
	logic [31:0] req_family_q;

	uf2c_pkg::reg_idx_t reg_sel;
	logic               wr_req;

	assign reg_sel = uf2c_pkg::reg_idx_t'(paddr[uf2c_pkg::ADDR_W-1:2]);
	assign wr_req  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_blocks_q <= uf2c_pkg::RST_TOTAL_BLOCKS;
			max_payload_q  <= uf2c_pkg::RST_MAX_PAYLOAD;
			magic_first_q  <= uf2c_pkg::RST_MAGIC_FIRST;
			magic_second_q <= uf2c_pkg::RST_MAGIC_SECOND;
			magic_final_q  <= uf2c_pkg::RST_MAGIC_FINAL;
			family_mask_q  <= uf2c_pkg::RST_FAMILY_MASK;
			req_family_q   <= uf2c_pkg::RST_REQ_FAMILY;
		end else if (wr_req) begin
			unique case (reg_sel)
				uf2c_pkg::REG_TOTAL_BLOCKS: total_blocks_q <= pwdata[15:0];
				uf2c_pkg::REG_MAX_PAYLOAD:  max_payload_q  <= pwdata[8:0];
				uf2c_pkg::REG_MAGIC_FIRST:  magic_first_q  <= pwdata;
				uf2c_pkg::REG_MAGIC_SECOND: magic_second_q <= pwdata;
				uf2c_pkg::REG_MAGIC_FINAL:  magic_final_q  <= pwdata;
				uf2c_pkg::REG_FAMILY_MASK:  family_mask_q  <= pwdata;
				uf2c_pkg::REG_REQ_FAMILY:   req_family_q   <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel)
			uf2c_pkg::REG_TOTAL_BLOCKS: prdata = {16'd0, total_blocks_q};
			uf2c_pkg::REG_MAX_PAYLOAD:  prdata = {23'd0, max_payload_q};
			uf2c_pkg::REG_MAGIC_FIRST:  prdata = magic_first_q;
			uf2c_pkg::REG_MAGIC_SECOND: prdata = magic_second_q;
			uf2c_pkg::REG_MAGIC_FINAL:  prdata = magic_final_q;
			uf2c_pkg::REG_FAMILY_MASK:  prdata = family_mask_q;
			uf2c_pkg::REG_REQ_FAMILY:   prdata = req_family_q;
			default:                    prdata = 32'd0;
		endcase
	end

	always_comb begin
		cls.magic_ok       = (start_word_a == magic_first_q) &&
		                     (start_word_b == magic_second_q) &&
		                     (end_word == magic_final_q);
		cls.size_ok        = payload_size <= {23'd0, max_payload_q};
		cls.count_ok       = block_total == {16'd0, total_blocks_q};
		// any flag bit that is also set in the family mask marks the last word as a family id
		cls.family         = ((block_flags & family_mask_q) != 32'd0) ? family_or_size : 32'd0;
		cls.block_number   = block_number;
		cls.target_address = target_address;
		cls.payload_size   = payload_size;
	end

	assign back_cfg.total_blocks    = total_blocks_q;
	assign back_cfg.required_family = req_family_q;

endmodule

// File: design/uf2c_queue.sv
// Two-entry queue of classified headers between front and back end.
// Depends on uf2c_pkg.
module uf2c_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr_en,
	input  uf2c_pkg::cls_t wr_data,
	output logic           full,
	input  logic           rd_en,
	output uf2c_pkg::cls_t rd_data,
	output logic           empty
);

	uf2c_pkg::cls_t mem_q [2];
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     count_q;

	assign full    = count_q == 2'd2;
	assign empty   = count_q == 2'd0;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (rd_en) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + 2'd1;
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

// File: design/uf2c_back.sv
// Back end: running image state, chain and family checks, sticky error and
// a two-entry result buffer. Depends on uf2c_pkg.
module uf2c_back (
	input  logic                clk,
	input  logic                arst_n,
	input  uf2c_pkg::back_cfg_t back_cfg,
	input  uf2c_pkg::cls_t      cls,
	input  logic                cls_empty,
	output logic                cls_take,
	output uf2c_pkg::result_t   res,
	output logic                res_empty,
	input  logic                res_pop
);

	uf2c_pkg::index_t  next_index_q;
	logic [31:0]       family_seen_q;
	logic [31:0]       start_address_q;
	logic [31:0]       stop_address_q;
	logic [31:0]       payload_sum_q;
	uf2c_pkg::status_t error_q;
	logic              finished_q;

	uf2c_pkg::result_t out_mem_q [2];
	logic              out_wr_q;
	logic              out_rd_q;
	logic [1:0]        out_cnt_q;

	uf2c_pkg::index_t  nxt_index;
	logic [31:0]       nxt_family;
	logic [31:0]       nxt_start;
	logic [31:0]       nxt_stop;
	logic [31:0]       nxt_sum;
	uf2c_pkg::status_t nxt_error;
	logic              nxt_finished;
	uf2c_pkg::status_t st;
	logic [31:0]       idx_ext;
	logic              is_last;
	logic              out_pop;
	uf2c_pkg::result_t new_res;

	assign out_pop   = res_pop && (out_cnt_q != 2'd0);
	assign cls_take  = !cls_empty && ((out_cnt_q != 2'd2) || out_pop);
	assign res_empty = out_cnt_q == 2'd0;
	assign res       = out_mem_q[out_rd_q];

	assign idx_ext = 32'(next_index_q);
	// 33-bit compare, so a narrow index that wraps never looks like the last block
	assign is_last = ({1'b0, idx_ext} + 33'd1) == {17'd0, back_cfg.total_blocks};

	always_comb begin
		nxt_index    = next_index_q;
		nxt_family   = family_seen_q;
		nxt_start    = start_address_q;
		nxt_stop     = stop_address_q;
		nxt_sum      = payload_sum_q;
		nxt_error    = error_q;
		nxt_finished = finished_q;
		st           = uf2c_pkg::ST_OK;
		priority if (error_q != uf2c_pkg::ST_OK) begin
			st = error_q;
		end else if (finished_q) begin
			st = uf2c_pkg::ST_VALID;
		end else if (back_cfg.total_blocks == 16'd0) begin
			nxt_error = uf2c_pkg::ST_EMPTY;
			st        = uf2c_pkg::ST_EMPTY;
		end else if (!cls.magic_ok) begin
			nxt_error = uf2c_pkg::ST_BAD_MAGIC;
			st        = uf2c_pkg::ST_BAD_MAGIC;
		end else if (!cls.size_ok) begin
			nxt_error = uf2c_pkg::ST_PAYLOAD_BIG;
			st        = uf2c_pkg::ST_PAYLOAD_BIG;
		end else if (!cls.count_ok) begin
			nxt_error = uf2c_pkg::ST_COUNT_MISMATCH;
			st        = uf2c_pkg::ST_COUNT_MISMATCH;
		end else if (cls.block_number != idx_ext) begin
			nxt_error = uf2c_pkg::ST_CHAIN_BROKEN;
			st        = uf2c_pkg::ST_CHAIN_BROKEN;
		end else if ((idx_ext != 32'd0) && (cls.family != family_seen_q)) begin
			nxt_error = uf2c_pkg::ST_FAMILY_CHANGED;
			st        = uf2c_pkg::ST_FAMILY_CHANGED;
		end else begin
			if (idx_ext == 32'd0) begin
				nxt_family = cls.family;
				nxt_start  = cls.target_address;
			end
			nxt_stop  = cls.target_address + cls.payload_size;
			nxt_sum   = payload_sum_q + cls.payload_size;
			nxt_index = next_index_q + uf2c_pkg::index_t'(1);
			if (is_last) begin
				nxt_finished = 1'b1;
				if (nxt_family != back_cfg.required_family) begin
					nxt_error = uf2c_pkg::ST_WRONG_FAMILY;
					st        = uf2c_pkg::ST_WRONG_FAMILY;
				end else begin
					st = uf2c_pkg::ST_VALID;
				end
			end
		end
		new_res.status        = st;
		new_res.block_index   = idx_ext[15:0];
		new_res.image_family  = nxt_family;
		new_res.first_address = nxt_start;
		new_res.end_address   = nxt_stop;
		new_res.payload_total = nxt_sum;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_index_q    <= '0;
			family_seen_q   <= 32'd0;
			start_address_q <= 32'd0;
			stop_address_q  <= 32'd0;
			payload_sum_q   <= 32'd0;
			error_q         <= uf2c_pkg::ST_OK;
			finished_q      <= 1'b0;
		end else if (cls_take) begin
			next_index_q    <= nxt_index;
			family_seen_q   <= nxt_family;
			start_address_q <= nxt_start;
			stop_address_q  <= nxt_stop;
			payload_sum_q   <= nxt_sum;
			error_q         <= nxt_error;
			finished_q      <= nxt_finished;
		end
	end

	always_ff @(posedge clk) begin
		if (cls_take) begin
			out_mem_q[out_wr_q] <= new_res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_wr_q  <= 1'b0;
			out_rd_q  <= 1'b0;
			out_cnt_q <= 2'd0;
		end else begin
			if (cls_take) begin
				out_wr_q <= ~out_wr_q;
			end
			if (out_pop) begin
				out_rd_q <= ~out_rd_q;
			end
			if (cls_take && !out_pop) begin
				out_cnt_q <= out_cnt_q + 2'd1;
			end else if (out_pop && !cls_take) begin
				out_cnt_q <= out_cnt_q - 2'd1;
			end
		end
	end

endmodule

// File: design/uf2_image_block_checker_top.sv
// Top level of the UF2 block checker: front end, header queue, back end.
// Depends on uf2c_pkg, uf2c_front, uf2c_queue and uf2c_back.
//
//   channel   handshake          payload
//   header    push / full        nine 32-bit header words
//   result    pop / empty        status, block_index, family, addresses, sum
//   config    psel/penable/...   seven registers at 4*i, pready tied high
//
// One header per cycle sustained while results are popped. A pushed header
// is registered in the two-entry queue, then its result in the result
// buffer; the back end's state update sets the rate. Results wait in a
// two-entry buffer; when that and the queue are full, full rises.
// Reset clears all control state and loads the register reset values.
module uf2_image_block_checker_top (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [uf2c_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	input  logic                        push,
	output logic                        full,
	input  logic [31:0]                 start_word_a,
	input  logic [31:0]                 start_word_b,
	input  logic [31:0]                 block_flags,
	input  logic [31:0]                 target_address,
	input  logic [31:0]                 payload_size,
	input  logic [31:0]                 block_number,
	input  logic [31:0]                 block_total,
	input  logic [31:0]                 family_or_size,
	input  logic [31:0]                 end_word,
	output logic                        empty,
	input  logic                        pop,
	output logic [3:0]                  status,
	output logic [15:0]                 block_index,
	output logic [31:0]                 image_family,
	output logic [31:0]                 first_address,
	output logic [31:0]                 end_address,
	output logic [31:0]                 payload_total
);

	uf2c_pkg::cls_t      cls_in;
	uf2c_pkg::cls_t      cls_out;
	uf2c_pkg::back_cfg_t back_cfg;
	uf2c_pkg::result_t   res;
	logic                q_empty;
	logic                q_take;
	logic                q_full;

	assign pready = 1'b1;
	assign full   = q_full;

	uf2c_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.start_word_a   (start_word_a),
		.start_word_b   (start_word_b),
		.block_flags    (block_flags),
		.target_address (target_address),
		.payload_size   (payload_size),
		.block_number   (block_number),
		.block_total    (block_total),
		.family_or_size (family_or_size),
		.end_word       (end_word),
		.cls            (cls_in),
		.back_cfg       (back_cfg)
	);

	uf2c_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (push && !q_full),
		.wr_data (cls_in),
		.full    (q_full),
		.rd_en   (q_take),
		.rd_data (cls_out),
		.empty   (q_empty)
	);

	uf2c_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.back_cfg  (back_cfg),
		.cls       (cls_out),
		.cls_empty (q_empty),
		.cls_take  (q_take),
		.res       (res),
		.res_empty (empty),
		.res_pop   (pop)
	);

	assign status        = 4'(res.status);
	assign block_index   = res.block_index;
	assign image_family  = res.image_family;
	assign first_address = res.first_address;
	assign end_address   = res.end_address;
	assign payload_total = res.payload_total;

endmodule

// File: test/uf2_image_block_checker_top_test.sv
`timescale 1ns / 100ps
// Self-checking bench for uf2_image_block_checker_top: runs UF2 header requests
// through the queue ports and checks every report against its own block model.
// Depends on uf2c_pkg and the checker RTL.
import uf2c_pkg::*;

typedef struct packed {
	logic [31:0] start_a;
	logic [31:0] start_b;
	logic [31:0] flags;
	logic [31:0] target;
	logic [31:0] psize;
	logic [31:0] number;
	logic [31:0] count;
	logic [31:0] fam_or_size;
	logic [31:0] end_magic;
} hdr_t;

class uf2_block_scoreboard;
	logic [15:0] tot;
	logic [8:0]  maxp;
	logic [31:0] mag_a, mag_b, mag_e, fam_mask, req_fam;
	index_t      nidx;
	logic [31:0] fam_seen, addr_first, addr_stop, psum;
	status_t     err;
	bit          done;
	result_t     awaited_reports[$];
	int          errors;

	function new();
		tot = RST_TOTAL_BLOCKS;
		maxp = RST_MAX_PAYLOAD;
		mag_a = RST_MAGIC_FIRST;
		mag_b = RST_MAGIC_SECOND;
		mag_e = RST_MAGIC_FINAL;
		fam_mask = RST_FAMILY_MASK;
		req_fam = RST_REQ_FAMILY;
		nidx = '0;
		fam_seen = '0;
		addr_first = '0;
		addr_stop = '0;
		psum = '0;
		err = ST_OK;
		done = 1'b0;
		errors = 0;
	endfunction

	function void set_reg(reg_idx_t r, logic [31:0] v);
		case (r)
			REG_TOTAL_BLOCKS: tot = v[15:0];
			REG_MAX_PAYLOAD:  maxp = v[8:0];
			REG_MAGIC_FIRST:  mag_a = v;
			REG_MAGIC_SECOND: mag_b = v;
			REG_MAGIC_FINAL:  mag_e = v;
			REG_FAMILY_MASK:  fam_mask = v;
			REG_REQ_FAMILY:   req_fam = v;
			default: ;
		endcase
	endfunction

	// predicts the report for one accepted header request
	function void note_header(hdr_t h);
		index_t      idx;
		logic [31:0] fam;
		status_t     st;
		result_t     r;
		idx = nidx;
		st = ST_OK;
		if (err != ST_OK) st = err;
		else if (done) st = ST_VALID;
		else if (tot == 16'd0) begin
			err = ST_EMPTY;
			st = err;
		end else begin
			fam = ((h.flags & fam_mask) != 0) ? h.fam_or_size : 32'd0;
			if (h.start_a != mag_a || h.start_b != mag_b || h.end_magic != mag_e)
				err = ST_BAD_MAGIC;
			else if (h.psize > 32'(maxp))
				err = ST_PAYLOAD_BIG;
			else if (h.count != 32'(tot))
				err = ST_COUNT_MISMATCH;
			else if (h.number != 32'(idx))
				err = ST_CHAIN_BROKEN;
			else if (idx != 0 && fam != fam_seen)
				err = ST_FAMILY_CHANGED;
			if (err != ST_OK) st = err;
			else begin
				if (idx == 0) begin
					fam_seen = fam;
					addr_first = h.target;
				end
				addr_stop = h.target + h.psize;
				psum = psum + h.psize;
				nidx = idx + 1'b1;
				if (17'(idx) + 17'd1 == 17'(tot)) begin
					done = 1'b1;
					if (fam_seen != req_fam) begin
						err = ST_WRONG_FAMILY;
						st = err;
					end else
						st = ST_VALID;
				end
			end
		end
		r.status = st;
		r.block_index = idx;
		r.image_family = fam_seen;
		r.first_address = addr_first;
		r.end_address = addr_stop;
		r.payload_total = psum;
		awaited_reports.push_back(r);
	endfunction

	function void compare_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			errors++;
			if (errors <= 10)
				$display("%s mismatch: expected %h, got %h", name, want, got);
		end
	endfunction

	function void check_report(result_t got);
		result_t want;
		if (awaited_reports.size() == 0) begin
			errors++;
			if (errors <= 10)
				$display("report with no header outstanding: status %h", got.status);
			return;
		end
		want = awaited_reports.pop_front();
		compare_field("status", 32'(want.status), 32'(got.status));
		compare_field("block_index", 32'(want.block_index), 32'(got.block_index));
		compare_field("image_family", want.image_family, got.image_family);
		compare_field("first_address", want.first_address, got.first_address);
		compare_field("end_address", want.end_address, got.end_address);
		compare_field("payload_total", want.payload_total, got.payload_total);
	endfunction

	function int pending();
		return awaited_reports.size();
	endfunction
endclass

module uf2_image_block_checker_top_test;
	localparam int STALL_LIMIT = 2000;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                psel = 1'b0;
	logic                penable = 1'b0;
	logic                pwrite = 1'b0;
	logic [ADDR_W-1:0]   paddr = '0;
	logic [31:0]         pwdata = '0;
	logic [31:0]         prdata;
	logic                pready;
	logic                push = 1'b0;
	logic                full;
	logic [31:0]         start_word_a = '0;
	logic [31:0]         start_word_b = '0;
	logic [31:0]         block_flags = '0;
	logic [31:0]         target_address = '0;
	logic [31:0]         payload_size = '0;
	logic [31:0]         block_number = '0;
	logic [31:0]         block_total = '0;
	logic [31:0]         family_or_size = '0;
	logic [31:0]         end_word = '0;
	logic                empty;
	logic                pop = 1'b0;
	logic [3:0]          status;
	logic [15:0]         block_index;
	logic [31:0]         image_family;
	logic [31:0]         first_address;
	logic [31:0]         end_address;
	logic [31:0]         payload_total;

	uf2_block_scoreboard sb;
	bit                  calm = 1'b0;
	logic [31:0]         fam_plan = '0;

	uf2_image_block_checker_top dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [31:0] mask_bit(logic [31:0] m);
		int p;
		p = $urandom_range(31);
		while (!m[p]) p = (p + 1) % 32;
		return 32'd1 << p;
	endfunction

	// total that no block of the next span requests can finish on
	function automatic logic [15:0] safe_total(int span);
		logic [15:0] w;
		do w = sb.nidx + 16'($urandom_range(65535, span)); while (w == 16'hFFFF);
		return w + 16'd1;
	endfunction

	function automatic hdr_t make_good();
		hdr_t        h;
		logic [31:0] fam;
		fam = (sb.nidx == 0) ? fam_plan : sb.fam_seen;
		h.start_a = sb.mag_a;
		h.start_b = sb.mag_b;
		h.end_magic = sb.mag_e;
		h.target = $urandom;
		if ($urandom_range(9) == 0) h.target = 32'hFFFF_FFFF - $urandom_range(511);
		case ($urandom_range(7))
			0: h.psize = 32'd0;
			1: h.psize = 32'(sb.maxp);
			default: h.psize = $urandom_range(32'(sb.maxp));
		endcase
		h.number = 32'(sb.nidx);
		h.count = 32'(sb.tot);
		if (fam != 0) begin
			h.flags = $urandom | mask_bit(sb.fam_mask);
			h.fam_or_size = fam;
		end else if (sb.fam_mask == 0 || $urandom_range(1)) begin
			h.flags = $urandom & ~sb.fam_mask;
			h.fam_or_size = $urandom;
		end else begin
			h.flags = $urandom | mask_bit(sb.fam_mask);
			h.fam_or_size = 32'd0;
		end
		return h;
	endfunction

	task automatic send(hdr_t h);
		while (!calm && $urandom_range(99) < 31) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		start_word_a <= h.start_a;
		start_word_b <= h.start_b;
		block_flags <= h.flags;
		target_address <= h.target;
		payload_size <= h.psize;
		block_number <= h.number;
		block_total <= h.count;
		family_or_size <= h.fam_or_size;
		end_word <= h.end_magic;
		do @(posedge clk); while (full);
		sb.note_header(h);
	endtask

	task automatic quiesce();
		push <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
	endtask

	// psel stays up after the access phase so writes can run back to back
	task automatic write_reg(reg_idx_t r, logic [31:0] v);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {r, 2'b00};
		pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		sb.set_reg(r, v);
	endtask

	task automatic end_writes();
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic reconfigure(int ph, int span, logic [31:0] mask);
		write_reg(REG_TOTAL_BLOCKS, 32'(safe_total(span)));
		case (ph % 3)
			0: write_reg(REG_MAX_PAYLOAD, 32'(RST_MAX_PAYLOAD));
			1: write_reg(REG_MAX_PAYLOAD, $urandom_range(476));
			default: write_reg(REG_MAX_PAYLOAD, 32'd0);
		endcase
		if (ph % 2) begin
			write_reg(REG_MAGIC_FIRST, $urandom);
			write_reg(REG_MAGIC_SECOND, $urandom);
			write_reg(REG_MAGIC_FINAL, $urandom);
		end else begin
			write_reg(REG_MAGIC_FIRST, RST_MAGIC_FIRST);
			write_reg(REG_MAGIC_SECOND, RST_MAGIC_SECOND);
			write_reg(REG_MAGIC_FINAL, RST_MAGIC_FINAL);
		end
		write_reg(REG_FAMILY_MASK, mask);
		write_reg(REG_REQ_FAMILY, $urandom);
		end_writes();
	endtask

	// report side
	initial begin
		result_t got;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (pop && !empty) begin
				got.status = status_t'(status);
				got.block_index = block_index;
				got.image_family = image_family;
				got.first_address = first_address;
				got.end_address = end_address;
				got.payload_total = payload_total;
				sb.check_report(got);
			end
			pop <= calm || ($urandom_range(99) >= 31);
		end
	end

	initial begin
		int stall;
		stall = 0;
		@(posedge arst_n);
		while (stall < STALL_LIMIT) begin
			@(posedge clk);
			if ((push && !full) || (pop && !empty) || (psel && penable)) stall = 0;
			else stall++;
		end
		$display("uf2_image_block_checker_top_test: errors");
		$finish;
	end

	initial begin
		hdr_t    h;
		status_t goal;
		sb = new();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: field extremes, address wrap, register extremes
		write_reg(REG_TOTAL_BLOCKS, 32'hFFFF);
		write_reg(REG_MAX_PAYLOAD, 32'(RST_MAX_PAYLOAD));
		write_reg(REG_MAGIC_FIRST, RST_MAGIC_FIRST);
		write_reg(REG_MAGIC_SECOND, RST_MAGIC_SECOND);
		write_reg(REG_MAGIC_FINAL, RST_MAGIC_FINAL);
		write_reg(REG_FAMILY_MASK, RST_FAMILY_MASK);
		write_reg(REG_REQ_FAMILY, $urandom);
		end_writes();
		fam_plan = $urandom | 32'd1;
		h = make_good();
		h.target = '0;
		h.psize = '0;
		h.flags = sb.fam_mask;
		send(h);
		h = make_good();
		h.target = '1;
		h.psize = 32'd476;
		send(h);
		// lands exactly on zero
		h = make_good();
		h.target = 32'hFFFF_FE24;
		h.psize = 32'd476;
		h.flags = '1;
		send(h);
		repeat (4) send(make_good());
		quiesce();
		write_reg(REG_MAX_PAYLOAD, 32'd0);
		write_reg(REG_FAMILY_MASK, '1);
		write_reg(REG_MAGIC_FIRST, '1);
		write_reg(REG_MAGIC_SECOND, '0);
		write_reg(REG_MAGIC_FINAL, '1);
		end_writes();
		repeat (4) send(make_good());
		quiesce();
		write_reg(REG_MAX_PAYLOAD, 32'd1);
		write_reg(REG_FAMILY_MASK, 32'h8000_0000);
		write_reg(REG_MAGIC_FIRST, '0);
		write_reg(REG_MAGIC_SECOND, '1);
		write_reg(REG_MAGIC_FINAL, '0);
		end_writes();
		repeat (4) send(make_good());

		// random well-formed image, settings changed between phases; one phase never idles
		for (int ph = 0; ph < 8; ph++) begin
			quiesce();
			reconfigure(ph, 170, (ph == 3) ? '1 : ($urandom | (32'd1 << $urandom_range(31))));
			calm = (ph == 5);
			repeat (170) send(make_good());
		end
		calm = 1'b0;
		quiesce();
		reconfigure(1, 30, $urandom | (32'd1 << $urandom_range(31)));
		repeat (30) send(make_good());

		// one way of ending the image, chosen by the seed
		goal = status_t'($urandom_range(ST_WRONG_FAMILY, ST_VALID));
		quiesce();
		write_reg(REG_FAMILY_MASK, $urandom | (32'd1 << $urandom_range(31)));
		case (goal)
			ST_VALID, ST_WRONG_FAMILY: begin
				write_reg(REG_TOTAL_BLOCKS, 32'(sb.nidx) + 32'd1);
				write_reg(REG_REQ_FAMILY, (goal == ST_VALID) ? sb.fam_seen : ~sb.fam_seen);
			end
			ST_EMPTY: write_reg(REG_TOTAL_BLOCKS, 32'd0);
			ST_PAYLOAD_BIG: write_reg(REG_MAX_PAYLOAD, $urandom_range(475));
			default: ;
		endcase
		end_writes();
		h = make_good();
		case (goal)
			ST_BAD_MAGIC: case ($urandom_range(2))
				0: h.start_a ^= 32'd1 << $urandom_range(31);
				1: h.start_b ^= 32'd1 << $urandom_range(31);
				default: h.end_magic ^= 32'd1 << $urandom_range(31);
			endcase
			ST_PAYLOAD_BIG: h.psize = $urandom_range(32'hFFFF_FFFF, 32'(sb.maxp) + 32'd1);
			ST_COUNT_MISMATCH: h.count ^= 32'd1 << $urandom_range(31);
			// bit 16 stands for an image longer than the index can count
			ST_CHAIN_BROKEN: h.number ^= 32'd1 << $urandom_range(31);
			ST_FAMILY_CHANGED: begin
				h.flags |= mask_bit(sb.fam_mask);
				h.fam_or_size = sb.fam_seen ^ (32'd1 << $urandom_range(31));
			end
			default: ;
		endcase
		send(h);
		repeat (5) send(make_good());

		// ignored from here on: raw noise, every bit both ways
		h = '1;
		send(h);
		h = '0;
		send(h);
		repeat (40) begin
			h = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
				$urandom, $urandom};
			send(h);
		end

		quiesce();
		repeat (8) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("uf2_image_block_checker_top_test: clean");
		else
			$display("uf2_image_block_checker_top_test: errors");
		$finish;
	end
endmodule
